>>> src/rau_pkg.sv
// ----------------------------------------------------------------------------
// rau_pkg
// Types and constants shared by the rational arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;

    // operand width used from each numerator and denominator field
    localparam int OW     = 16;
    // working width of the internal magnitude datapath
    localparam int W      = 2 * OW;
    localparam int NUM_W  = 35;
    localparam int DEN_W  = 32;
    localparam int STEP_W = $clog2(W + 2);
    localparam int K_W    = $clog2(W + 1);

    // operation codes
    localparam logic [1:0] MODE_ADD = 2'd0;
    localparam logic [1:0] MODE_SUB = 2'd1;
    localparam logic [1:0] MODE_MUL = 2'd2;
    localparam logic [1:0] MODE_DIV = 2'd3;

    // status codes
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_ZERO_DEN = 2'd1;
    localparam logic [1:0] STATUS_DIV_ZERO = 2'd2;

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [15:0] x_num;
        logic [15:0]        x_den;
        logic signed [15:0] y_num;
        logic [15:0]        y_den;
    } in_t;

    typedef struct packed {
        logic signed [NUM_W-1:0] result_num;
        logic [DEN_W-1:0]        result_den;
        logic [1:0]              status;
    } out_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_GCD1,
        ST_DIV1,
        ST_DIV2,
        ST_MUL0,
        ST_MUL1,
        ST_MUL2,
        ST_ADD,
        ST_CHK,
        ST_GCD2,
        ST_DIV3,
        ST_DIV4,
        ST_FINISH
    } state_t;

endpackage

>>> src/rational_arithmetic_unit.sv
// Sequence: an error transaction goes straight to the output state; otherwise one
// or two binary gcd runs (one subtract or shift a cycle) and two or four restoring
// divisions reduce the result; a zero result skips the final gcd run and divisions.
// Throughput: one transaction at a time; s_ready is high only while idle, and a
// result held by m_ready low stalls the sequencer in its last state.
// Reset: synchronous active-low aresetn clears the sequencer and m_valid.
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// Adds, subtracts, multiplies or divides two fractions and reduces the result
// by the gcd, with the sign on the numerator.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  rau_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output rau_pkg::out_t m_data
);

    localparam int OW = rau_pkg::OW;
    localparam int W  = rau_pkg::W;

    rau_pkg::state_t state_reg, state_next;

    logic [1:0]              mode_reg;
    logic [1:0]              status_reg;
    logic                    xn_reg, yn_reg, neg_reg;
    logic [OW-1:0]           xm_reg, ym_reg, xd_reg, yd_reg;
    logic [W-1:0]            q1_reg, q2_reg, num_reg, b_reg, den_reg;
    logic [W-1:0]            ga_reg, gb_reg, g_reg;
    logic [rau_pkg::K_W-1:0] k_reg;
    logic [W:0]              rem_reg;
    logic [W-1:0]            quo_reg;
    logic [rau_pkg::STEP_W-1:0] step_reg;
    logic                    m_valid_reg;
    rau_pkg::out_t           m_data_reg;

    // input operand split into sign and magnitude
    logic [OW-1:0] x_raw, y_raw, x_mag, y_mag, x_dn, y_dn;
    logic          x_neg, y_neg;
    logic [1:0]    status_in;

    assign x_raw = s_data.x_num[OW-1:0];
    assign y_raw = s_data.y_num[OW-1:0];
    assign x_neg = x_raw[OW-1];
    assign y_neg = y_raw[OW-1];
    assign x_mag = x_neg ? (OW'(0) - x_raw) : x_raw;
    assign y_mag = y_neg ? (OW'(0) - y_raw) : y_raw;
    assign x_dn  = s_data.x_den[OW-1:0];
    assign y_dn  = s_data.y_den[OW-1:0];

    always_comb begin
        if (x_dn == '0 || y_dn == '0) begin
            status_in = rau_pkg::STATUS_ZERO_DEN;
        end else if (s_data.mode == rau_pkg::MODE_DIV && y_mag == '0) begin
            status_in = rau_pkg::STATUS_DIV_ZERO;
        end else begin
            status_in = rau_pkg::STATUS_OK;
        end
    end

    logic lin_mode;
    assign lin_mode = (mode_reg == rau_pkg::MODE_ADD) || (mode_reg == rau_pkg::MODE_SUB);

    // shared multiplier
    logic [OW-1:0] mul_a, mul_b;
    logic [W-1:0]  mul_p;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            rau_pkg::ST_MUL0: begin
                mul_a = xm_reg;
                if (lin_mode) begin
                    mul_b = q2_reg[OW-1:0];
                end else if (mode_reg == rau_pkg::MODE_MUL) begin
                    mul_b = ym_reg;
                end else begin
                    mul_b = yd_reg;
                end
            end
            rau_pkg::ST_MUL1: begin
                if (lin_mode) begin
                    mul_a = ym_reg;
                    mul_b = q1_reg[OW-1:0];
                end else if (mode_reg == rau_pkg::MODE_MUL) begin
                    mul_a = xd_reg;
                    mul_b = yd_reg;
                end else begin
                    mul_a = xd_reg;
                    mul_b = ym_reg;
                end
            end
            rau_pkg::ST_MUL2: begin
                mul_a = q1_reg[OW-1:0];
                mul_b = yd_reg;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = W'(mul_a) * W'(mul_b);

    // shared restoring divider, one quotient bit a cycle
    logic [W:0]   div_sh;
    logic         div_ge;
    logic         div_done;
    logic [W-1:0] div_dvd;

    assign div_sh   = {rem_reg[W-1:0], quo_reg[W-1]};
    assign div_ge   = div_sh >= {1'b0, g_reg};
    assign div_done = step_reg == rau_pkg::STEP_W'(W + 1);

    always_comb begin
        case (state_reg)
            rau_pkg::ST_DIV1: div_dvd = W'(xd_reg);
            rau_pkg::ST_DIV2: div_dvd = W'(yd_reg);
            rau_pkg::ST_DIV3: div_dvd = num_reg;
            rau_pkg::ST_DIV4: div_dvd = den_reg;
            default:          div_dvd = '0;
        endcase
    end

    // shared binary gcd step
    logic gcd_done;
    assign gcd_done = (step_reg != '0) && (ga_reg == '0 || gb_reg == '0);

    // sign-magnitude add for add and subtract
    logic         b_neg;
    logic [W-1:0] add_mag;
    logic         add_neg;

    always_comb begin
        b_neg = yn_reg ^ (mode_reg == rau_pkg::MODE_SUB);
        if (b_reg == '0) begin
            b_neg = 1'b0;
        end
        if (xn_reg == b_neg) begin
            add_neg = xn_reg;
            add_mag = num_reg + b_reg;
        end else if (num_reg >= b_reg) begin
            add_neg = xn_reg;
            add_mag = num_reg - b_reg;
        end else begin
            add_neg = b_neg;
            add_mag = b_reg - num_reg;
        end
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rau_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and handshake
    logic out_load;

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            rau_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (status_in != rau_pkg::STATUS_OK) begin
                        state_next = rau_pkg::ST_FINISH;
                    end else if (s_data.mode == rau_pkg::MODE_ADD ||
                                 s_data.mode == rau_pkg::MODE_SUB) begin
                        state_next = rau_pkg::ST_GCD1;
                    end else begin
                        state_next = rau_pkg::ST_MUL0;
                    end
                end
            end
            rau_pkg::ST_GCD1: if (gcd_done) state_next = rau_pkg::ST_DIV1;
            rau_pkg::ST_DIV1: if (div_done) state_next = rau_pkg::ST_DIV2;
            rau_pkg::ST_DIV2: if (div_done) state_next = rau_pkg::ST_MUL0;
            rau_pkg::ST_MUL0: state_next = rau_pkg::ST_MUL1;
            rau_pkg::ST_MUL1: state_next = lin_mode ? rau_pkg::ST_MUL2 : rau_pkg::ST_CHK;
            rau_pkg::ST_MUL2: state_next = rau_pkg::ST_ADD;
            rau_pkg::ST_ADD:  state_next = rau_pkg::ST_CHK;
            rau_pkg::ST_CHK: begin
                state_next = (num_reg == '0) ? rau_pkg::ST_FINISH : rau_pkg::ST_GCD2;
            end
            rau_pkg::ST_GCD2: if (gcd_done) state_next = rau_pkg::ST_DIV3;
            rau_pkg::ST_DIV3: if (div_done) state_next = rau_pkg::ST_DIV4;
            rau_pkg::ST_DIV4: if (div_done) state_next = rau_pkg::ST_FINISH;
            rau_pkg::ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = rau_pkg::ST_IDLE;
                end
            end
            default: state_next = rau_pkg::ST_IDLE;
        endcase
    end

    // step counter, restarts on every state change
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= '0;
        end else if (state_next != state_reg) begin
            step_reg <= '0;
        end else if (step_reg != '1) begin
            step_reg <= step_reg + 1'b1;
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            rau_pkg::ST_IDLE: begin
                if (s_valid) begin
                    mode_reg   <= s_data.mode;
                    status_reg <= status_in;
                    xn_reg     <= x_neg;
                    yn_reg     <= y_neg;
                    xm_reg     <= x_mag;
                    ym_reg     <= y_mag;
                    xd_reg     <= x_dn;
                    yd_reg     <= y_dn;
                end
            end
            rau_pkg::ST_GCD1, rau_pkg::ST_GCD2: begin
                if (step_reg == '0) begin
                    ga_reg <= (state_reg == rau_pkg::ST_GCD1) ? W'(xd_reg) : num_reg;
                    gb_reg <= (state_reg == rau_pkg::ST_GCD1) ? W'(yd_reg) : den_reg;
                    k_reg  <= '0;
                end else if (gcd_done) begin
                    g_reg <= (ga_reg | gb_reg) << k_reg;
                end else begin
                    case ({ga_reg[0], gb_reg[0]})
                        2'b00: begin
                            ga_reg <= ga_reg >> 1;
                            gb_reg <= gb_reg >> 1;
                            k_reg  <= k_reg + 1'b1;
                        end
                        2'b01: ga_reg <= ga_reg >> 1;
                        2'b10: gb_reg <= gb_reg >> 1;
                        default: begin
                            if (ga_reg >= gb_reg) begin
                                ga_reg <= (ga_reg - gb_reg) >> 1;
                            end else begin
                                gb_reg <= (gb_reg - ga_reg) >> 1;
                            end
                        end
                    endcase
                end
            end
            rau_pkg::ST_DIV1, rau_pkg::ST_DIV2, rau_pkg::ST_DIV3, rau_pkg::ST_DIV4: begin
                if (step_reg == '0) begin
                    rem_reg <= '0;
                    quo_reg <= div_dvd;
                end else if (!div_done) begin
                    rem_reg <= div_ge ? (div_sh - {1'b0, g_reg}) : div_sh;
                    quo_reg <= {quo_reg[W-2:0], div_ge};
                end else begin
                    case (state_reg)
                        rau_pkg::ST_DIV1: q1_reg  <= quo_reg;
                        rau_pkg::ST_DIV2: q2_reg  <= quo_reg;
                        rau_pkg::ST_DIV3: num_reg <= quo_reg;
                        default:          den_reg <= quo_reg;
                    endcase
                end
            end
            rau_pkg::ST_MUL0: begin
                num_reg <= mul_p;
                neg_reg <= xn_reg ^ yn_reg;
            end
            rau_pkg::ST_MUL1: begin
                if (lin_mode) begin
                    b_reg <= mul_p;
                end else begin
                    den_reg <= mul_p;
                end
            end
            rau_pkg::ST_MUL2: den_reg <= mul_p;
            rau_pkg::ST_ADD: begin
                num_reg <= add_mag;
                neg_reg <= add_neg;
            end
            default: begin
            end
        endcase
    end

    // output register
    logic [rau_pkg::NUM_W-1:0] num_ext;
    assign num_ext = rau_pkg::NUM_W'(num_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg.status <= status_reg;
            if (status_reg != rau_pkg::STATUS_OK || num_reg == '0) begin
                m_data_reg.result_num <= '0;
                m_data_reg.result_den <= rau_pkg::DEN_W'(1);
            end else begin
                m_data_reg.result_num <= neg_reg ? (rau_pkg::NUM_W'(0) - num_ext) : num_ext;
                m_data_reg.result_den <= rau_pkg::DEN_W'(den_reg);
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef NO_ASSERTIONS
    // an error status always carries 0/1
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != rau_pkg::STATUS_OK |->
            m_data.result_num == '0 && m_data.result_den == rau_pkg::DEN_W'(1))
        else $error("error status without 0/1 result");

    // denominator never zero
    a_den_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.result_den != '0)
        else $error("zero result denominator");

    // busy after accepting a transaction
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("ready while a transaction is in flight");
`endif

endmodule

>>> verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives fraction pairs with all four operations into the rational unit,
// predicts the reduced fraction and status for each one, and compares every
// result in order, with random gaps and back-pressure on both channels.
// ----------------------------------------------------------------------------
module testbench;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int N_RANDOM       = 1630;

    logic           aclk;
    logic           aresetn;
    logic           s_valid;
    logic           s_ready;
    rau_pkg::in_t   s_data;
    logic           m_valid;
    logic           m_ready;
    rau_pkg::out_t  m_data;

    rau_pkg::in_t   pending_fractions[$];
    rau_pkg::out_t  expected_fractions[$];
    int    mismatches;
    int    results_seen;
    int    idle_cycles;
    logic  gen_done;
    logic  in_taken;
    int    send_gap;
    int    take_gap;

    rational_arithmetic_unit u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic longint unsigned gcd64(longint unsigned a, longint unsigned b);
        longint unsigned r;
        while (b != 0) begin
            r = a % b;
            a = b;
            b = r;
        end
        return a;
    endfunction

    // exact rational result of one transaction
    function automatic rau_pkg::out_t reduce_fraction(rau_pkg::in_t t);
        rau_pkg::out_t   o;
        logic            xn, yn, bn, rn;
        longint unsigned xm, ym, xd, yd, g, l, a, b, rm, rd;
        longint signed   sn;
        xn = t.x_num[15];
        yn = t.y_num[15];
        xm = xn ? 64'(-32'(t.x_num)) : 64'(t.x_num);
        ym = yn ? 64'(-32'(t.y_num)) : 64'(t.y_num);
        xd = 64'(t.x_den);
        yd = 64'(t.y_den);
        rn = 1'b0;
        rm = 0;
        rd = 1;
        o.status = rau_pkg::STATUS_OK;
        if (xd == 0 || yd == 0) begin
            o.status = rau_pkg::STATUS_ZERO_DEN;
        end else if (t.mode == rau_pkg::MODE_DIV && ym == 0) begin
            o.status = rau_pkg::STATUS_DIV_ZERO;
        end else if (t.mode == rau_pkg::MODE_ADD || t.mode == rau_pkg::MODE_SUB) begin
            g  = gcd64(xd, yd);
            l  = (xd / g) * yd;
            a  = xm * (l / xd);
            b  = ym * (l / yd);
            bn = (t.mode == rau_pkg::MODE_SUB) ? !yn : yn;
            if (b == 0) bn = 1'b0;
            if (xn == bn) begin
                rn = xn;
                rm = a + b;
            end else if (a >= b) begin
                rn = xn;
                rm = a - b;
            end else begin
                rn = bn;
                rm = b - a;
            end
            rd = l;
        end else if (t.mode == rau_pkg::MODE_MUL) begin
            rm = xm * ym;
            rn = xn != yn;
            rd = xd * yd;
        end else begin
            rm = xm * yd;
            rn = xn != yn;
            rd = xd * ym;
        end
        if (o.status != rau_pkg::STATUS_OK || rm == 0) begin
            rm = 0;
            rn = 1'b0;
            rd = 1;
        end else begin
            g  = gcd64(rm, rd);
            rm = rm / g;
            rd = rd / g;
        end
        sn = rn ? -longint'(rm) : longint'(rm);
        o.result_num = sn[rau_pkg::NUM_W-1:0];
        o.result_den = rd[rau_pkg::DEN_W-1:0];
        return o;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 92) return $urandom_range(1, 4);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic [15:0] rand_den();
        case ($urandom_range(0, 7))
            0:       return 16'($urandom_range(1, 12));
            1:       return 16'hFFFF;
            2:       return 16'($urandom_range(0, 3));
            3, 4:    return 16'($urandom_range(1, 255));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] rand_num();
        case ($urandom_range(0, 7))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'($urandom_range(0, 2));
            3:       return -16'($urandom_range(1, 60));
            4:       return 16'($urandom_range(1, 60));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic rau_pkg::in_t make_fraction(logic [1:0] m, logic [15:0] xn,
                                                   logic [15:0] xd, logic [15:0] yn,
                                                   logic [15:0] yd);
        rau_pkg::in_t t;
        t.mode  = m;
        t.x_num = xn;
        t.x_den = xd;
        t.y_num = yn;
        t.y_den = yd;
        return t;
    endfunction

    // stimulus
    initial begin
        logic [1:0] m;
        aresetn    = 1'b0;
        gen_done   = 1'b0;
        for (int i = 0; i < 4; i++) begin
            case (i)
                0: m = rau_pkg::MODE_ADD;
                1: m = rau_pkg::MODE_SUB;
                2: m = rau_pkg::MODE_MUL;
                default: m = rau_pkg::MODE_DIV;
            endcase
            pending_fractions.push_back(make_fraction(m, 16'h8000, 16'hFFFF, 16'h8000, 16'hFFFE));
            pending_fractions.push_back(make_fraction(m, 16'h7FFF, 16'd1, 16'h8000, 16'd1));
            pending_fractions.push_back(make_fraction(m, 16'd3, 16'd0, 16'd5, 16'd7));
            pending_fractions.push_back(make_fraction(m, 16'd0, 16'd4, 16'd0, 16'd6));
        end
        // zero divisor fraction, zero result, cancelling sum, missing y denominator
        pending_fractions.push_back(make_fraction(rau_pkg::MODE_DIV, 16'd5, 16'd3, 16'd0, 16'd9));
        pending_fractions.push_back(make_fraction(rau_pkg::MODE_SUB, 16'd2, 16'd4, 16'd1, 16'd2));
        pending_fractions.push_back(make_fraction(rau_pkg::MODE_ADD, -16'd3, 16'd6, 16'd1,
                                                  16'd2));
        pending_fractions.push_back(make_fraction(rau_pkg::MODE_MUL, 16'd1, 16'd5, 16'd1, 16'd0));
        pending_fractions.push_back(make_fraction(rau_pkg::MODE_DIV, 16'hFFFF, 16'hFFFF,
                                                  16'hFFFF, 16'h8000));
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == N_RANDOM / 2) begin
                // hold the sender until the unit has drained
                wait (pending_fractions.size() == 0 && expected_fractions.size() == 0);
            end
            pending_fractions.push_back(make_fraction(2'($urandom), rand_num(), rand_den(),
                                                      rand_num(), rand_den()));
            while (pending_fractions.size() > 4) @(posedge aclk);
        end
        gen_done = 1'b1;
    end

    // input acceptance seen at the rising edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= s_valid && s_ready;
        end
    end

    // driver
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid  <= 1'b0;
            s_data   <= '0;
            send_gap <= 0;
        end else if (in_taken) begin
            // transaction taken at the last rising edge
            expected_fractions.push_back(reduce_fraction(s_data));
            void'(pending_fractions.pop_front());
            if (pending_fractions.size() > 0 && pick_gap() == 0) begin
                s_data <= pending_fractions[0];
            end else begin
                s_valid  <= 1'b0;
                send_gap <= pick_gap();
            end
        end else if (!s_valid) begin
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
            end else if (pending_fractions.size() > 0) begin
                s_valid <= 1'b1;
                s_data  <= pending_fractions[0];
            end
        end
    end

    // result side back-pressure
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready  <= 1'b0;
            take_gap <= 0;
        end else if (take_gap > 0) begin
            m_ready  <= 1'b0;
            take_gap <= take_gap - 1;
        end else begin
            m_ready <= 1'b1;
            if (m_valid && m_ready) take_gap <= pick_gap();
        end
    end

    // monitor
    always @(posedge aclk) begin
        rau_pkg::out_t exp_r;
        if (!aresetn) begin
            mismatches   <= 0;
            results_seen <= 0;
            idle_cycles  <= 0;
        end else begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (m_valid && m_ready) begin
                results_seen <= results_seen + 1;
                if (expected_fractions.size() == 0) begin
                    if (mismatches < 10)
                        $display("unexpected result num=%0d den=%0d status=%0d",
                                 m_data.result_num, m_data.result_den, m_data.status);
                    mismatches <= mismatches + 1;
                end else begin
                    exp_r = expected_fractions.pop_front();
                    if (exp_r !== m_data) begin
                        if (mismatches < 10)
                            $display("mismatch exp %0d/%0d st %0d, got %0d/%0d st %0d",
                                     exp_r.result_num, exp_r.result_den, exp_r.status,
                                     m_data.result_num, m_data.result_den, m_data.status);
                        mismatches <= mismatches + 1;
                    end
                end
            end
        end
    end

    // end of run and watchdog
    initial begin
        @(posedge aresetn);
        fork
            begin
                wait (gen_done && pending_fractions.size() == 0 &&
                      expected_fractions.size() == 0);
                repeat (400) @(posedge aclk);
            end
            begin
                wait (idle_cycles >= WATCHDOG_LIMIT);
            end
        join_any
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired, %0d results outstanding", expected_fractions.size());
            $display("TB_ERROR");
        end else begin
            $display("covered %0d transactions over add, subtract, multiply and divide,",
                     results_seen);
            $display("including zero denominators, zero divisors and extreme operands");
            if (mismatches == 0 && expected_fractions.size() == 0) begin
                $display("TB_OK");
            end else begin
                $display("%0d mismatches", mismatches);
                $display("TB_ERROR");
            end
        end
        $finish;
    end

endmodule
